// ----- src/psd_pkg.sv -----
// shared types and constants of the port scan detector
`default_nettype none
package psd_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int PORT_BITS = 16;
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int BM_WORDS = ((1 << PORT_BITS) + 63) / 64;
	localparam int BM_WW = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
	localparam int BM_DEPTH = TABLE_SLOTS * BM_WORDS;
	localparam int BM_AW = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
	localparam int EPOCH_W = 32;
	localparam int COUNT_W = 17;
	localparam int TIME_W = 63;
	localparam int SPAN_W = 42;
	localparam int NS_PER_US = 1000;

	localparam logic [1:0] REG_LAN = 2'd0;
	localparam logic [1:0] REG_WAN = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;
	localparam logic [1:0] REG_EXPIRY = 2'd3;

	typedef enum logic {
		KIND_DONE = 1'b0,
		KIND_WAN  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [3:0]            out_port;
		logic                  dropped;
		logic [31:0]           src;
		logic [PORT_BITS-1:0]  port;
		logic [TIME_W-1:0]     now;
	} item_t;

	typedef struct packed {
		logic [3:0]  lan_port;
		logic [3:0]  wan_port;
		logic [15:0] port_limit;
	} cfg_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [63:0]        bits;
	} bm_word_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [COUNT_W-1:0] count;
	} info_t;

endpackage
`default_nettype wire

// ----- src/port_scan_detector.sv -----
// throughput: one packet per cycle for inside-port and dropped packets while the output is not
// stalled; an outside-port packet is taken only after the lookup, select and bitmap
// read-modify-write steps of the previous one are done and its result has been accepted
// reset: registers return to defaults and the table empties; a clearing pass then sweeps all
// 65536 bitmap memory words, during which no packet is taken
`default_nettype none
module port_scan_detector (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [119:0]  s_tdata,  // arrival_port, source_address, dest_port, now_ns
	input  wire logic [0:0]    s_tuser,  // is_l4
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata,  // out_port, dropped, scan_detected
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	psd_pkg::cfg_t                 cfg;
	logic [31:0]                   expiry_q;
	logic [psd_pkg::SPAN_W-1:0]    span_q;
	logic                          q_full;
	logic                          q_empty;
	logic                          push;
	logic                          pop;
	logic                          clear_done;
	psd_pkg::item_t                push_item;
	psd_pkg::item_t                head;
	logic [3:0]                    out_port;
	logic                          dropped;
	logic                          scan_detected;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.lan_port <= 4'd0;
			cfg.wan_port <= 4'd1;
			cfg.port_limit <= 16'd64;
			expiry_q <= 32'd1000000;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				psd_pkg::REG_LAN: cfg.lan_port <= pwdata[3:0];
				psd_pkg::REG_WAN: cfg.wan_port <= pwdata[3:0];
				psd_pkg::REG_LIMIT: cfg.port_limit <= pwdata[15:0];
				psd_pkg::REG_EXPIRY: expiry_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			psd_pkg::REG_LAN: prdata = {28'd0, cfg.lan_port};
			psd_pkg::REG_WAN: prdata = {28'd0, cfg.wan_port};
			psd_pkg::REG_LIMIT: prdata = {16'd0, cfg.port_limit};
			psd_pkg::REG_EXPIRY: prdata = expiry_q;
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		span_q <= psd_pkg::SPAN_W'(expiry_q) * psd_pkg::SPAN_W'(psd_pkg::NS_PER_US);
	end

	psd_front u_front (
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.arrival_port   (s_tdata[3:0]),
		.is_l4          (s_tuser[0]),
		.source_address (s_tdata[35:4]),
		.dest_port      (s_tdata[51:36]),
		.now_ns         (s_tdata[114:52]),
		.cfg            (cfg),
		.q_full         (q_full),
		.clear_done     (clear_done),
		.push           (push),
		.item           (push_item)
	);

	psd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	psd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.span          (span_q),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.clear_done    (clear_done),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.out_port      (out_port),
		.dropped       (dropped),
		.scan_detected (scan_detected)
	);

	assign m_tdata = {2'd0, scan_detected, dropped, out_port};

endmodule
`default_nettype wire

// ----- src/psd_front.sv -----
// front end: accepts packets and classifies them into queue items
`default_nettype none
module psd_front (
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [3:0]               arrival_port,
	input  wire logic                     is_l4,
	input  wire logic [31:0]              source_address,
	input  wire logic [15:0]              dest_port,
	input  wire logic [62:0]              now_ns,
	input  wire psd_pkg::cfg_t            cfg,
	input  wire logic                     q_full,
	input  wire logic                     clear_done,
	output logic                          push,
	output psd_pkg::item_t                item
);

	assign s_tready = !q_full && clear_done;
	assign push = s_tvalid && s_tready;

	always_comb begin
		item.kind = psd_pkg::KIND_DONE;
		item.out_port = arrival_port;
		item.dropped = 1'b1;
		item.src = source_address;
		item.port = dest_port[psd_pkg::PORT_BITS-1:0];
		item.now = now_ns;
		if (!is_l4) begin
			item.dropped = 1'b1;
		end else if (arrival_port == cfg.lan_port) begin
			item.out_port = cfg.wan_port;
			item.dropped = 1'b0;
		end else if (arrival_port == cfg.wan_port) begin
			item.kind = psd_pkg::KIND_WAN;
		end
	end

endmodule
`default_nettype wire

// ----- src/psd_fifo.sv -----
// two-entry queue between front and back
`default_nettype none
module psd_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire psd_pkg::item_t   push_item,
	input  wire logic             pop,
	output psd_pkg::item_t        head,
	output logic                  empty,
	output logic                  full
);

	psd_pkg::item_t entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head = entry_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ----- src/psd_back.sv -----
// back end: source table lookup, port bitmap update and result register
`default_nettype none
module psd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire psd_pkg::cfg_t                  cfg,
	input  wire logic [psd_pkg::SPAN_W-1:0]     span,
	input  wire psd_pkg::item_t                 head,
	input  wire logic                           empty,
	output logic                                pop,
	output logic                                clear_done,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [3:0]                          out_port,
	output logic                                dropped,
	output logic                                scan_detected
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_THR  = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_SEL  = 5'b01000,
		ST_UPD  = 5'b10000
	} state_t;

	localparam int S = psd_pkg::TABLE_SLOTS;

	state_t state_q;
	psd_pkg::item_t it_q;

	logic                          valid_q [S];
	logic [31:0]                   source_q [S];
	logic [psd_pkg::TIME_W-1:0]    seen_q [S];

	psd_pkg::bm_word_t bm_mem [psd_pkg::BM_DEPTH];
	psd_pkg::info_t    info_mem [S];
	psd_pkg::bm_word_t bm_rd_q;
	psd_pkg::info_t    info_rd_q;

	logic [psd_pkg::BM_AW-1:0]     clr_cnt_q;
	logic                          clr_busy_q;

	logic                          old_q;
	logic [psd_pkg::TIME_W-1:0]    thr_q;
	logic [S-1:0]                  live_q;
	logic [S-1:0]                  match_q;

	logic [psd_pkg::SLOT_W-1:0]    sel_s;
	logic                          hit_s;
	logic                          free_s;
	logic [psd_pkg::BM_AW-1:0]     bm_addr_s;

	logic [psd_pkg::SLOT_W-1:0]    sel_c;
	logic                          hit_c;
	logic                          free_c;
	logic [psd_pkg::BM_AW-1:0]     bm_addr_c;
	logic [psd_pkg::BM_WW-1:0]     word_c;
	logic [5:0]                    bit_c;
	logic [15:0]                   port16;

	logic [63:0]                   bit_mask;
	logic [63:0]                   cur_bits;
	logic                          new_port;
	logic [psd_pkg::COUNT_W-1:0]   count_nx;
	logic [psd_pkg::EPOCH_W-1:0]   epoch_nx;
	logic                          scan_c;
	logic                          out_free;
	logic                          upd_wr;
	psd_pkg::bm_word_t             bm_wdata;
	psd_pkg::info_t                info_wdata;

	assign clear_done = !clr_busy_q;
	assign out_free = !m_tvalid || m_tready;

	assign pop = (state_q == ST_IDLE) && !empty && clear_done &&
		((head.kind == psd_pkg::KIND_DONE) ? out_free : !m_tvalid);

	assign port16 = 16'(it_q.port);
	assign word_c = psd_pkg::BM_WW'(port16 >> 6);
	assign bit_c = port16[5:0];

	always_comb begin
		sel_c = '0;
		hit_c = 1'b0;
		free_c = 1'b0;
		for (int i = S - 1; i >= 0; i--) begin
			if (!hit_c || match_q[i]) begin
				if (match_q[i]) begin
					hit_c = 1'b1;
				end
			end
		end
		for (int i = S - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				sel_c = psd_pkg::SLOT_W'(i);
			end
		end
		if (!hit_c) begin
			for (int i = S - 1; i >= 0; i--) begin
				if (!live_q[i]) begin
					sel_c = psd_pkg::SLOT_W'(i);
					free_c = 1'b1;
				end
			end
		end
	end

	assign bm_addr_c = psd_pkg::BM_AW'(psd_pkg::BM_AW'(sel_c) *
		psd_pkg::BM_AW'(psd_pkg::BM_WORDS)) + psd_pkg::BM_AW'(word_c);

	always_comb begin
		bit_mask = 64'd1 << bit_c;
		cur_bits = (bm_rd_q.tag == info_rd_q.epoch) ? bm_rd_q.bits : 64'd0;
		new_port = ((cur_bits & bit_mask) == 64'd0);
		count_nx = info_rd_q.count + psd_pkg::COUNT_W'(new_port);
		epoch_nx = (info_rd_q.epoch == '1) ? psd_pkg::EPOCH_W'(1) :
			info_rd_q.epoch + psd_pkg::EPOCH_W'(1);
		scan_c = hit_s && (count_nx > psd_pkg::COUNT_W'(cfg.port_limit));
		upd_wr = (state_q == ST_UPD) && (hit_s || free_s);
		if (hit_s) begin
			bm_wdata.tag = info_rd_q.epoch;
			bm_wdata.bits = cur_bits | bit_mask;
			info_wdata.epoch = info_rd_q.epoch;
			info_wdata.count = count_nx;
		end else begin
			bm_wdata.tag = epoch_nx;
			bm_wdata.bits = bit_mask;
			info_wdata.epoch = epoch_nx;
			info_wdata.count = psd_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			bm_mem[clr_cnt_q] <= '0;
		end else if (upd_wr) begin
			bm_mem[bm_addr_s] <= bm_wdata;
		end
		if (state_q == ST_SEL) begin
			bm_rd_q <= bm_mem[bm_addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q && (clr_cnt_q < psd_pkg::BM_AW'(S))) begin
			info_mem[clr_cnt_q[psd_pkg::SLOT_W-1:0]] <= '0;
		end else if (upd_wr) begin
			info_mem[sel_s] <= info_wdata;
		end
		if (state_q == ST_SEL) begin
			info_rd_q <= info_mem[sel_c];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			it_q <= head;
		end
		if (state_q == ST_THR) begin
			old_q <= (it_q.now < psd_pkg::TIME_W'(span));
			thr_q <= it_q.now - psd_pkg::TIME_W'(span);
		end
		if (state_q == ST_CMP) begin
			for (int i = 0; i < S; i++) begin
				live_q[i] <= valid_q[i] && (old_q || (seen_q[i] >= thr_q));
				match_q[i] <= valid_q[i] && (old_q || (seen_q[i] >= thr_q)) &&
					(source_q[i] == it_q.src);
			end
		end
		if (state_q == ST_SEL) begin
			sel_s <= sel_c;
			hit_s <= hit_c;
			free_s <= free_c;
			bm_addr_s <= bm_addr_c;
		end
		if (upd_wr) begin
			seen_q[sel_s] <= it_q.now;
			source_q[sel_s] <= it_q.src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_busy_q <= 1'b1;
			clr_cnt_q <= '0;
			m_tvalid <= 1'b0;
			out_port <= '0;
			dropped <= 1'b0;
			scan_detected <= 1'b0;
			for (int i = 0; i < S; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + psd_pkg::BM_AW'(1);
				if (clr_cnt_q == psd_pkg::BM_AW'(psd_pkg::BM_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (pop && (head.kind == psd_pkg::KIND_DONE)) begin
				m_tvalid <= 1'b1;
			end else if (state_q == ST_UPD) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.kind == psd_pkg::KIND_DONE) begin
							out_port <= head.out_port;
							dropped <= head.dropped;
							scan_detected <= 1'b0;
						end else begin
							state_q <= ST_THR;
						end
					end
				end
				ST_THR: state_q <= ST_CMP;
				ST_CMP: state_q <= ST_SEL;
				ST_SEL: state_q <= ST_UPD;
				ST_UPD: begin
					if (free_s && !hit_s) begin
						valid_q[sel_s] <= 1'b1;
					end
					out_port <= scan_c ? it_q.out_port : cfg.lan_port;
					dropped <= scan_c;
					scan_detected <= scan_c;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- tb/sv/port_scan_detector_checker.sv -----
// checker for the port scan detector: tracks config, predicts each verdict and compares
`default_nettype none
module port_scan_detector_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [119:0] s_tdata,
	input  wire logic [0:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [7:0]   m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	input  wire logic         pready,
	output int                failures,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		bit [3:0] dev;
		bit       drop;
		bit       scan;
	} verdict_t;

	bit [3:0]  lan_dev = 4'd0;
	bit [3:0]  wan_dev = 4'd1;
	bit [15:0] limit = 16'd64;
	bit [31:0] expiry = 32'd1000000;

	bit              used [psd_pkg::TABLE_SLOTS];
	bit [31:0]       owner [psd_pkg::TABLE_SLOTS];
	bit [62:0]       seen_at [psd_pkg::TABLE_SLOTS];
	bit [16:0]       distinct [psd_pkg::TABLE_SLOTS];
	int unsigned     generation [psd_pkg::TABLE_SLOTS];
	int unsigned     port_marks [bit [21:0]];
	verdict_t        verdict_q [$];

	assign outstanding = verdict_q.size();

	function automatic verdict_t judge(bit [3:0] dev, bit l4, bit [31:0] src,
			bit [15:0] dport, bit [62:0] now);
		verdict_t v;
		int hit;
		int free_slot;
		bit [63:0] span;
		bit live;
		bit [21:0] key;
		v.dev = dev;
		v.drop = 1'b1;
		v.scan = 1'b0;
		if (!l4) begin
		end else if (dev == lan_dev) begin
			v.dev = wan_dev;
			v.drop = 1'b0;
		end else if (dev == wan_dev) begin
			span = 64'(expiry) * 64'd1000;
			hit = -1;
			free_slot = -1;
			for (int s = 0; s < psd_pkg::TABLE_SLOTS; s++) begin
				live = used[s] && ({1'b0, now} < span || {1'b0, seen_at[s]} >= {1'b0, now} - span);
				if (live) begin
					if (hit < 0 && owner[s] == src) hit = s;
				end else if (free_slot < 0) begin
					free_slot = s;
				end
			end
			if (hit >= 0) begin
				seen_at[hit] = now;
				key = {hit[5:0], dport};
				if (!(port_marks.exists(key) && port_marks[key] == generation[hit])) begin
					port_marks[key] = generation[hit];
					distinct[hit] = distinct[hit] + 17'd1;
				end
				v.scan = distinct[hit] > {1'b0, limit};
			end else if (free_slot >= 0) begin
				used[free_slot] = 1'b1;
				owner[free_slot] = src;
				seen_at[free_slot] = now;
				generation[free_slot]++;
				port_marks[{free_slot[5:0], dport}] = generation[free_slot];
				distinct[free_slot] = 17'd1;
			end
			if (!v.scan) begin
				v.dev = lan_dev;
				v.drop = 1'b0;
			end
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			lan_dev <= 4'd0;
			wan_dev <= 4'd1;
			limit <= 16'd64;
			expiry <= 32'd1000000;
			failures <= 0;
			for (int s = 0; s < psd_pkg::TABLE_SLOTS; s++) used[s] = 1'b0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					psd_pkg::REG_LAN: lan_dev <= pwdata[3:0];
					psd_pkg::REG_WAN: wan_dev <= pwdata[3:0];
					psd_pkg::REG_LIMIT: limit <= pwdata[15:0];
					psd_pkg::REG_EXPIRY: expiry <= pwdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				verdict_q.push_back(judge(s_tdata[3:0], s_tuser[0], s_tdata[35:4],
					s_tdata[51:36], s_tdata[114:52]));
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$error("result transfer with nothing expected: %h", m_tdata);
					errs++;
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[3:0] != want.dev) begin
						$error("out_port expected %0d actual %0d", want.dev, m_tdata[3:0]);
						errs++;
					end
					if (m_tdata[4] != want.drop) begin
						$error("dropped expected %0d actual %0d", want.drop, m_tdata[4]);
						errs++;
					end
					if (m_tdata[5] != want.scan) begin
						$error("scan_detected expected %0d actual %0d", want.scan, m_tdata[5]);
						errs++;
					end
				end
			end
			failures <= failures + errs;
		end
	end

endmodule
`default_nettype wire

// ----- tb/sv/port_scan_detector_test.sv -----
// top of the port scan detector testbench: clock, reset, stimulus and verdict
`default_nettype none
module port_scan_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	int           failures;
	int           outstanding;
	bit           calm = 1'b0;
	int           stall_left = 0;
	int           quiet_cycles = 0;

	localparam int WATCHDOG = 200000;

	always #4 clk = ~clk;

	port_scan_detector dut (.*);

	port_scan_detector_checker checker_i (.*);

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_packet(bit [3:0] dev, bit l4, bit [31:0] src, bit [15:0] dport,
			bit [62:0] now);
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, now, dport, src, dev};
		s_tuser <= l4;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	bit [3:0]  lan_of [5] = '{4'd0, 4'd15, 4'd5, 4'd2, 4'd7};
	bit [3:0]  wan_of [5] = '{4'd1, 4'd14, 4'd5, 4'd9, 4'd3};
	bit [15:0] limit_of [5] = '{16'd64, 16'd3, 16'd0, 16'hffff, 16'd8};
	bit [31:0] expiry_of [5] = '{32'd1000000, 32'd1, 32'd0, 32'hffffffff, 32'd50};

	initial begin
		bit [31:0] pool [96];
		bit [62:0] t;
		bit [3:0]  dev;
		bit [31:0] src;
		bit [15:0] dport;
		int        pick;
		int        burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: drop rules, miss, hit, expiry and time going backwards
		send_packet(4'd1, 1'b0, 32'h12345678, 16'd80, 63'd0);
		send_packet(4'd0, 1'b1, 32'h0, 16'h0, 63'd0);
		send_packet(4'd1, 1'b1, 32'hffffffff, 16'hffff, 63'd0);
		send_packet(4'd1, 1'b1, 32'hffffffff, 16'hffff, 63'd10);
		send_packet(4'd1, 1'b1, 32'hffffffff, 16'h0, 63'd20);
		send_packet(4'd15, 1'b1, 32'hffffffff, 16'h1, 63'd30);
		send_packet(4'd15, 1'b0, 32'h0, 16'h1, 63'd30);
		send_packet(4'd1, 1'b1, 32'h0, 16'h0, 63'h7fffffffffffffff);
		send_packet(4'd1, 1'b1, 32'h0, 16'h5, 63'd5);
		send_packet(4'd1, 1'b1, 32'hffffffff, 16'h5, 63'd6);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			reg_write(psd_pkg::REG_LAN, {28'h0, lan_of[ph]});
			reg_write(psd_pkg::REG_WAN, {28'h0, wan_of[ph]});
			reg_write(psd_pkg::REG_LIMIT, {16'h0, limit_of[ph]});
			reg_write(psd_pkg::REG_EXPIRY, expiry_of[ph]);
			foreach (pool[k]) pool[k] = $urandom;
			t = 63'($urandom_range(0, 1000));
			for (int i = 0; i < 212; i++) begin
				if (ph == 4 && i >= 110) calm = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 2) t = 63'({$urandom, $urandom} >> 1);
				else if (pick < 4) t = t - 63'($urandom_range(0, 5000));
				else if (pick < 14) t = t + 63'($urandom_range(0, 200000));
				else t = t + 63'($urandom_range(0, 300));
				src = pool[$urandom_range(0, 95)];
				if ($urandom_range(0, 49) == 0) begin
					// one source walking many ports
					burst = $urandom_range(10, 70);
					for (int b = 0; b < burst; b++)
						send_packet(wan_of[ph], 1'b1, src, 16'(b * 3 + $urandom_range(0, 2)),
							t + 63'(b));
					t = t + 63'(burst);
					continue;
				end
				pick = $urandom_range(0, 9);
				dev = pick < 6 ? wan_of[ph] : pick < 8 ? lan_of[ph] : 4'($urandom);
				if ($urandom_range(0, 9) == 0) src = $urandom;
				dport = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
				send_packet(dev, $urandom_range(0, 9) != 0, src, dport, t);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
